// ----- hw/rtl/vth_pkg.sv -----
// Package for the homogeneous vertex transform: widths, request and result types,
// pipeline metadata and small arithmetic helpers. No dependencies.
`default_nettype none

package vth_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS  = 16;
    localparam int COEF_WIDTH = 32;
    localparam int POS_W      = 32;
    localparam int PROD_W     = POS_W + 32;          // one coefficient product
    localparam int PAIR_W     = PROD_W + 1;          // sum of two terms
    localparam int SUM_W      = PROD_W + 2;          // full row sum
    localparam int ROW_W      = SUM_W - FRAC_BITS;   // row sum after the shift
    localparam int DIVN_W     = POS_W + FRAC_BITS;   // dividend magnitude
    localparam int DIVD_W     = ROW_W;               // divisor magnitude
    localparam int REM_W      = DIVD_W + 1;
    localparam int CFG_NUM    = 8;
    localparam int CFG_AW     = $clog2(CFG_NUM);
    localparam int CFG_W      = 64;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_ROW0_C01 = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_ROW0_C23 = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_ROW1_C01 = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_ROW1_C23 = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] REG_ROW2_C01 = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] REG_ROW2_C23 = CFG_AW'(5);
    localparam logic [CFG_AW-1:0] REG_ROW3_C01 = CFG_AW'(6);
    localparam logic [CFG_AW-1:0] REG_ROW3_C23 = CFG_AW'(7);

    // Identity matrix at reset
    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + 32);

    // Command codes
    localparam logic CMD_AFFINE = 1'b0;
    localparam logic CMD_HOMOG  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_req;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic              w_was_zero;
        logic              saturated;
    } t_res;

    // Side data carried beside the dividers
    typedef struct packed {
        logic              div;
        logic              wzero;
        logic              sat;
        logic              neg_x;
        logic              neg_y;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_meta;

    // Coefficient from one 32-bit half: low COEF_WIDTH bits, two's complement
    function automatic logic signed [31:0] coef_of(input logic [31:0] half);
        logic signed [COEF_WIDTH-1:0] c;
        begin
            c = half[COEF_WIDTH-1:0];
            return 32'(c);
        end
    endfunction

    // Clamp a shifted row sum to 32 bits
    function automatic logic signed [POS_W-1:0] clamp_row(
        input logic signed [ROW_W-1:0] v, output logic sat);
        logic signed [ROW_W-1:0] vmax;
        logic signed [ROW_W-1:0] vmin;
        begin
            vmax = ROW_W'(32'sh7fffffff);
            vmin = -vmax - ROW_W'(1);
            sat  = 1'b0;
            if (v > vmax) begin
                sat = 1'b1;
                return POS_W'(vmax);
            end else if (v < vmin) begin
                sat = 1'b1;
                return POS_W'(vmin);
            end
            return POS_W'(v);
        end
    endfunction

    // Apply the sign to a quotient magnitude and clamp to 32 bits
    function automatic logic signed [POS_W-1:0] sign_clamp(
        input logic [DIVN_W-1:0] q, input logic neg, output logic sat);
        logic [DIVN_W-1:0] lim;
        begin
            lim = DIVN_W'(1) << (POS_W - 1);
            sat = 1'b0;
            if (neg) begin
                if (q > lim) begin
                    sat = 1'b1;
                    return POS_W'(lim);
                end
                return POS_W'(-q);
            end
            if (q >= lim) begin
                sat = 1'b1;
                return POS_W'(lim - DIVN_W'(1));
            end
            return POS_W'(q);
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vth_row.sv -----
// One matrix row: four registered products, two registered pair sums and the full sum.
// Depends on vth_pkg.
`default_nettype none

module vth_row (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [vth_pkg::POS_W-1:0]  i_x,
    input  wire logic signed [vth_pkg::POS_W-1:0]  i_y,
    input  wire logic signed [vth_pkg::POS_W-1:0]  i_z,
    input  wire logic signed [31:0]                i_c0,
    input  wire logic signed [31:0]                i_c1,
    input  wire logic signed [31:0]                i_c2,
    input  wire logic signed [31:0]                i_c3,
    output logic signed [vth_pkg::ROW_W-1:0]       o_row
);
    import vth_pkg::*;

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [PAIR_W-1:0] r_s01, r_s23;
    logic signed [SUM_W-1:0]  r_sum;

    // Stage 1: products, translation term scaled by one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_x * i_c0;
            r_p1 <= i_y * i_c1;
            r_p2 <= i_z * i_c2;
            r_p3 <= PROD_W'(i_c3) <<< FRAC_BITS;
        end
    end

    // Stage 2: pair sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s01 <= PAIR_W'(r_p0) + PAIR_W'(r_p1);
            r_s23 <= PAIR_W'(r_p2) + PAIR_W'(r_p3);
        end
    end

    // Stage 3: full sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SUM_W'(r_s01) + SUM_W'(r_s23);
        end
    end

    // Floor shift by the fraction width
    assign o_row = r_sum[SUM_W-1:FRAC_BITS];

endmodule

`default_nettype wire

// ----- hw/rtl/vth_div.sv -----
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on vth_pkg.
`default_nettype none

module vth_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [vth_pkg::DIVN_W-1:0]  i_num,
    input  wire logic [vth_pkg::DIVD_W-1:0]  i_den,
    output logic [vth_pkg::DIVN_W-1:0]       o_quo
);
    import vth_pkg::*;

    logic [REM_W-1:0]  r_rem [DIVN_W];
    logic [DIVN_W-1:0] r_num [DIVN_W];
    logic [DIVN_W-1:0] r_quo [DIVN_W];
    logic [DIVD_W-1:0] r_den [DIVN_W];

    genvar g;
    generate
        for (g = 0; g < DIVN_W; g++) begin : g_stage
            logic [REM_W-1:0]  rem_in;
            logic [DIVN_W-1:0] num_in;
            logic [DIVN_W-1:0] quo_in;
            logic [DIVD_W-1:0] den_in;
            logic [REM_W-1:0]  trial;
            logic [REM_W-1:0]  n_rem;
            logic              n_bit;

            if (g == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = i_num;
                assign quo_in = '0;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign num_in = r_num[g-1];
                assign quo_in = r_quo[g-1];
                assign den_in = r_den[g-1];
            end

            // Shift in one dividend bit, subtract when it fits
            always_comb begin
                trial = {rem_in[REM_W-2:0], num_in[DIVN_W-1]};
                n_bit = (trial >= REM_W'(den_in));
                n_rem = n_bit ? (trial - REM_W'(den_in)) : trial;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_num[g] <= {num_in[DIVN_W-2:0], 1'b0};
                    r_quo[g] <= {quo_in[DIVN_W-2:0], n_bit};
                    r_den[g] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIVN_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/vth_obuf.sv -----
// Two-entry result buffer between the pipeline and the output channel.
// Depends on vth_pkg.
`default_nettype none

module vth_obuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vth_pkg::t_res  i_data,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_stall,
    output vth_pkg::t_res       o_data
);
    import vth_pkg::*;

    t_res       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt != 2'd2);
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (pop)    r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vertex_transform_homogeneous.sv -----
// Top level of the homogeneous 4x4 vertex transform with perspective divide.
// Depends on vth_pkg, vth_row, vth_div and vth_obuf.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  request | in        | i_valid / o_stall  | i_req  (cmd, pos_x/y/z)
//  result  | out       | o_valid / i_stall  | o_res  (out_x/y/z, flags)
//  config  | in        | i_cfg_we           | i_cfg_addr, i_cfg_data
//
// One request per cycle while the result buffer has room. The input register
// loads at the accepting edge; o_valid rises after 3 row stages (multiply, pair
// add, full add), clamp stage, 48 divider stages, sign stage and the buffer write.
// Reset loads the identity matrix and empties the pipeline.
// The whole pipeline holds while the two-entry result buffer is full.
`default_nettype none

module vertex_transform_homogeneous (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire vth_pkg::t_req                     i_req,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output vth_pkg::t_res                          o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [vth_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [vth_pkg::CFG_W-1:0]         i_cfg_data
);
    import vth_pkg::*;

    localparam int ROW_LAT = 3;

    logic [CFG_W-1:0] r_cfg [CFG_NUM];
    logic             en;
    logic             room;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROW0_C01] <= ONE_LO;
            r_cfg[REG_ROW0_C23] <= '0;
            r_cfg[REG_ROW1_C01] <= ONE_HI;
            r_cfg[REG_ROW1_C23] <= '0;
            r_cfg[REG_ROW2_C01] <= '0;
            r_cfg[REG_ROW2_C23] <= ONE_LO;
            r_cfg[REG_ROW3_C01] <= '0;
            r_cfg[REG_ROW3_C23] <= ONE_HI;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_data;
        end
    end

    assign en      = room;
    assign o_stall = !en;

    // Input register
    t_req r_in;
    logic r_v0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) r_in <= i_req;
    end

    // Four row units
    logic signed [ROW_W-1:0] row [4];
    genvar gr;
    generate
        for (gr = 0; gr < 4; gr++) begin : g_row
            vth_row u_row (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (r_in.pos_x),
                .i_y   (r_in.pos_y),
                .i_z   (r_in.pos_z),
                .i_c0  (coef_of(r_cfg[2*gr][31:0])),
                .i_c1  (coef_of(r_cfg[2*gr][63:32])),
                .i_c2  (coef_of(r_cfg[2*gr+1][31:0])),
                .i_c3  (coef_of(r_cfg[2*gr+1][63:32])),
                .o_row (row[gr])
            );
        end
    endgenerate

    // Command and valid beside the row units
    logic r_vr [ROW_LAT];
    logic r_cr [ROW_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROW_LAT; i++) r_vr[i] <= 1'b0;
        end else if (en) begin
            r_vr[0] <= r_v0;
            for (int i = 1; i < ROW_LAT; i++) r_vr[i] <= r_vr[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cr[0] <= r_in.cmd;
            for (int i = 1; i < ROW_LAT; i++) r_cr[i] <= r_cr[i-1];
        end
    end

    // Clamp stage: saturate x/y/z, test w, take magnitudes for the divider
    t_meta                 n_meta;
    logic [DIVN_W-1:0]     n_num_x, n_num_y;
    logic [DIVD_W-1:0]     n_den;
    always_comb begin
        logic              sx, sy, sz;
        logic              wz;
        logic [POS_W-1:0]  mx, my;
        n_meta.x     = clamp_row(row[0], sx);
        n_meta.y     = clamp_row(row[1], sy);
        n_meta.z     = clamp_row(row[2], sz);
        wz           = (row[3] == '0);
        n_meta.sat   = sx | sy | sz;
        n_meta.wzero = (r_cr[ROW_LAT-1] == CMD_HOMOG) && wz;
        n_meta.div   = (r_cr[ROW_LAT-1] == CMD_HOMOG) && !wz;
        n_meta.neg_x = n_meta.x[POS_W-1] ^ row[3][ROW_W-1];
        n_meta.neg_y = n_meta.y[POS_W-1] ^ row[3][ROW_W-1];
        mx           = n_meta.x[POS_W-1] ? POS_W'(-n_meta.x) : POS_W'(n_meta.x);
        my           = n_meta.y[POS_W-1] ? POS_W'(-n_meta.y) : POS_W'(n_meta.y);
        n_num_x      = {mx, FRAC_BITS'(0)};
        n_num_y      = {my, FRAC_BITS'(0)};
        n_den        = row[3][ROW_W-1] ? DIVD_W'(-row[3]) : DIVD_W'(row[3]);
    end

    t_meta             r_meta;
    logic              r_v4;
    logic [DIVN_W-1:0] r_num_x, r_num_y;
    logic [DIVD_W-1:0] r_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_vr[ROW_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta  <= n_meta;
            r_num_x <= n_num_x;
            r_num_y <= n_num_y;
            r_den   <= n_den;
        end
    end

    // Dividers for x and y
    logic [DIVN_W-1:0] quo_x, quo_y;
    vth_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_x),
        .i_den (r_den),
        .o_quo (quo_x)
    );
    vth_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_y),
        .i_den (r_den),
        .o_quo (quo_y)
    );

    // Side data delay matching the dividers
    t_meta r_md [DIVN_W];
    logic  r_vd [DIVN_W];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIVN_W; i++) r_vd[i] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v4;
            for (int i = 1; i < DIVN_W; i++) r_vd[i] <= r_vd[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md[0] <= r_meta;
            for (int i = 1; i < DIVN_W; i++) r_md[i] <= r_md[i-1];
        end
    end

    // Sign stage: apply signs, clamp quotients, pick divided or affine values
    t_res n_res;
    always_comb begin
        t_meta             m;
        logic              qsx, qsy;
        logic signed [POS_W-1:0] qx, qy;
        m  = r_md[DIVN_W-1];
        qx = sign_clamp(quo_x, m.neg_x, qsx);
        qy = sign_clamp(quo_y, m.neg_y, qsy);
        n_res.out_x      = m.div ? qx : m.x;
        n_res.out_y      = m.div ? qy : m.y;
        n_res.out_z      = m.z;
        n_res.w_was_zero = m.wzero;
        n_res.saturated  = m.sat | (m.div & (qsx | qsy));
    end

    t_res r_res;
    logic r_vf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en) begin
            r_vf <= r_vd[DIVN_W-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) r_res <= n_res;
    end

    // Result buffer
    vth_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && r_vf),
        .i_data  (r_res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_res)
    );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for vertex_transform_homogeneous: streams requests, predicts each result
// with a fixed-point model of the matrix transform and checks it. Depends on vth_pkg.
`timescale 1ns / 1ps

module tb;
    import vth_pkg::*;

    // Scoreboard: holds the matrix copy and the queue of predicted results
    class xform_board;
        logic [63:0] mtx_regs [CFG_NUM];
        t_res        pending [$];
        int          errors;

        function void load_identity();
            mtx_regs[0] = ONE_LO;
            mtx_regs[1] = '0;
            mtx_regs[2] = ONE_HI;
            mtx_regs[3] = '0;
            mtx_regs[4] = '0;
            mtx_regs[5] = ONE_LO;
            mtx_regs[6] = '0;
            mtx_regs[7] = ONE_HI;
            errors = 0;
        endfunction

        function logic signed [63:0] coef_at(int row, int col);
            logic [63:0] r;
            logic [31:0] half;
            logic signed [COEF_WIDTH-1:0] c;
            r = mtx_regs[row * 2 + col / 2];
            half = (col % 2) ? r[63:32] : r[31:0];
            c = half[COEF_WIDTH-1:0];
            return 64'(c);
        endfunction

        // Full-width dot product, floored shift by FRAC_BITS
        function logic signed [79:0] row_sum(int row, logic signed [31:0] x,
                                              logic signed [31:0] y, logic signed [31:0] z);
            logic signed [79:0] acc;
            acc = 80'(x) * 80'(coef_at(row, 0)) + 80'(y) * 80'(coef_at(row, 1))
                + 80'(z) * 80'(coef_at(row, 2)) + (80'(coef_at(row, 3)) <<< FRAC_BITS);
            return acc >>> FRAC_BITS;
        endfunction

        function logic signed [79:0] clip(logic signed [79:0] v, ref logic sat);
            if (v > 80'sd2147483647) begin
                sat = 1'b1;
                return 80'sd2147483647;
            end
            if (v < -80'sd2147483648) begin
                sat = 1'b1;
                return -80'sd2147483648;
            end
            return v;
        endfunction

        function void note_request(t_req rq);
            t_res r;
            logic sat;
            logic signed [79:0] rx, ry, rz, w;
            sat = 1'b0;
            rx = clip(row_sum(0, rq.pos_x, rq.pos_y, rq.pos_z), sat);
            ry = clip(row_sum(1, rq.pos_x, rq.pos_y, rq.pos_z), sat);
            rz = clip(row_sum(2, rq.pos_x, rq.pos_y, rq.pos_z), sat);
            r.w_was_zero = 1'b0;
            if (rq.cmd == CMD_HOMOG) begin
                w = row_sum(3, rq.pos_x, rq.pos_y, rq.pos_z);
                if (w == 0) r.w_was_zero = 1'b1;
                else begin
                    // SV signed division truncates toward zero
                    rx = clip((rx <<< FRAC_BITS) / w, sat);
                    ry = clip((ry <<< FRAC_BITS) / w, sat);
                end
            end
            r.out_x = rx[31:0];
            r.out_y = ry[31:0];
            r.out_z = rz[31:0];
            r.saturated = sat;
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
            if (got.w_was_zero !== want.w_was_zero)
                report("w_was_zero", got.w_was_zero, want.w_was_zero);
            if (got.saturated !== want.saturated)
                report("saturated", got.saturated, want.saturated);
        endtask
    endclass

    logic        i_clk, i_rst_n, i_valid, i_stall, i_cfg_we;
    logic        o_stall, o_valid;
    t_req        i_req;
    t_res        o_res;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_data;

    xform_board board;
    int  cycles;
    bit  hold_long;
    bit  sink_quiet;

    vertex_transform_homogeneous uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Monitor: check accepted requests and results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) board.note_request(i_req);
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_res);
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_long = 1'b0;
            end
            if (sink_quiet) gap = 0;
            else gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) gap = 0;
            i_stall = (gap != 0);
            if (gap != 0) begin
                repeat (gap - 1) @(negedge i_clk);
                i_stall = 1'b0;
            end
            // stay ready until a result is taken
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input int idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = CFG_AW'(idx);
        i_cfg_data = val;
        board.mtx_regs[idx] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offer one request, with a random lead-in gap, and hold it until taken
    task automatic send_point(input t_req rq, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req = rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic logic [31:0] rand_coef(int shape);
        case (shape)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 16)));
        endcase
    endfunction

    task automatic random_points(input int count, input int shape);
        t_req rq;
        for (int k = 0; k < count; k++) begin
            rq.cmd = $urandom_range(0, 1) ? CMD_HOMOG : CMD_AFFINE;
            rq.pos_x = rand_coord(shape == 4 ? $urandom_range(0, 3) : shape);
            rq.pos_y = rand_coord(shape == 4 ? $urandom_range(0, 3) : shape);
            rq.pos_z = rand_coord(shape == 4 ? $urandom_range(0, 3) : shape);
            send_point(rq, (k % 100) < 20);
        end
    endtask

    initial begin
        t_req rq;
        logic [31:0] edges [6];
        board = new();
        board.load_identity();
        cycles = 0;
        hold_long = 1'b0;
        sink_quiet = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: identity matrix, field extremes, both commands
        edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000, 32'h1};
        for (int k = 0; k < 12; k++) begin
            rq.cmd = (k % 2) ? CMD_HOMOG : CMD_AFFINE;
            rq.pos_x = edges[k % 6];
            rq.pos_y = edges[(k + 2) % 6];
            rq.pos_z = edges[(k + 4) % 6];
            send_point(rq, 1'b0);
        end
        drain();

        // Zero w: row 3 all zero; and w in [0,1) via small translation
        write_reg(REG_ROW3_C01, 64'h0);
        write_reg(REG_ROW3_C23, 64'h0000_0000_0000_0000);
        rq = '{CMD_HOMOG, 32'h00020000, 32'hfffe0000, 32'h00050000};
        send_point(rq, 1'b0);
        drain();
        write_reg(REG_ROW3_C23, 64'h0000_8000_0000_0000);
        send_point(rq, 1'b0);
        drain();
        // Tiny w forces quotient clamp; negative w
        write_reg(REG_ROW3_C23, 64'h0000_0001_0000_0000);
        rq = '{CMD_HOMOG, 32'h7fffffff, 32'h80000000, 32'h1};
        send_point(rq, 1'b0);
        drain();
        write_reg(REG_ROW3_C23, 64'hffff_0000_0000_0000);
        rq = '{CMD_HOMOG, 32'h00030000, 32'hfff00000, 32'h0};
        send_point(rq, 1'b0);
        drain();
        // Large coefficients push row sums out of range
        write_reg(REG_ROW0_C01, 64'h7fffffff_7fffffff);
        write_reg(REG_ROW1_C01, 64'h80000000_80000000);
        rq = '{CMD_AFFINE, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
        send_point(rq, 1'b0);
        drain();

        // Random phases, each with a fresh matrix
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < CFG_NUM; r++)
                write_reg(r, {rand_coef(ph % 4 == 2 ? 2 : $urandom_range(0, 3)),
                              rand_coef(ph % 4 == 2 ? 2 : $urandom_range(0, 3))});
            if (ph == 3) begin
                hold_long = 1'b1;
                sink_quiet = 1'b1;
            end
            random_points(120, ph == 5 ? 0 : 4);
            sink_quiet = 1'b0;
            drain();
        end

        // Back to identity so the reset-style matrix is seen under random points
        board.load_identity();
        for (int r = 0; r < CFG_NUM; r++) write_reg(r, board.mtx_regs[r]);
        random_points(40, 4);
        drain();

        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
